// ----- sv/sfm_pkg.sv -----
// Shared types and constants for the sensor freshness monitor.
// Holds the request/result transaction structs and request codes.
// No dependencies.
package sfm_pkg;

    // Request codes (req_type / reply_kind)
    localparam logic [2:0] REQ_UPDATE      = 3'd0;
    localparam logic [2:0] REQ_TICK        = 3'd1;
    localparam logic [2:0] REQ_READ_TEMP   = 3'd2;
    localparam logic [2:0] REQ_READ_ONLINE = 3'd3;
    localparam logic [2:0] REQ_GATHER_ROOM = 3'd4;
    localparam logic [2:0] REQ_GATHER_OUT  = 3'd5;

    // Longest gather list
    localparam int unsigned MAX_RESULTS = 9;

    // Configuration space: one 32-bit register
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         slot_id;
        logic signed [15:0] temperature_in;
    } req_t;

    typedef struct packed {
        logic [2:0]         reply_kind;
        logic               ok;
        logic signed [15:0] reading;
        logic [3:0]         list_index;
        logic               last;
    } rsp_t;

endpackage

// ----- sv/sensor_freshness_monitor_unit.sv -----
// Sensor freshness monitor: slot table, tick-based aging, reads and gathers.
// Depends on sfm_pkg (types, request codes, constants).
//
//  Channel   Signals                                   Direction  Transaction when
//  --------  ----------------------------------------  ---------  -----------------------
//  request   start, busy, req                          in         start & !busy at clk
//  result    rsp_valid, rsp                            out        rsp_valid (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     psel & penable & pwrite
//            prdata, pready
//
// Update, read online and rejected ids answer in the cycle after the transaction
// and leave busy low. Other requests step a slot index through the
// reading/stamp memories, a fetch state (read port) then an evaluate state per
// slot (one age compare or online test); the final result is valid in the same
// cycle that busy drops. Read temperature visits one slot, a tick every slot, a
// gather its slot range, stopping once the list is full, then a closing state.
// Reset (rst_n low) clears the online flags and the tick and loads the default
// timeout; slot memories need no clearing pass. Results cannot be stalled.
module sensor_freshness_monitor_unit
    import sfm_pkg::*;
#(
    parameter int unsigned SENSOR_SLOTS = 11,
    parameter int unsigned ROOM_SLOTS   = 9
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    // result
    output logic                  rsp_valid,
    output rsp_t                  rsp,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned IDX_W    = $clog2(SENSOR_SLOTS);
    localparam int unsigned PAD_N    = 2 ** IDX_W;
    localparam int unsigned ROOM_EFF = (ROOM_SLOTS < SENSOR_SLOTS) ? ROOM_SLOTS : SENSOR_SLOTS;
    localparam bit          OUT_EMPTY = (ROOM_EFF >= SENSOR_SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(SENSOR_SLOTS - 1);
    localparam logic [IDX_W-1:0] ROOM_LAST  = IDX_W'(ROOM_EFF - 1);
    localparam logic [IDX_W-1:0] OUT_FIRST  = IDX_W'(ROOM_EFF);
    localparam logic [7:0]       SLOTS_ID   = 8'(SENSOR_SLOTS);
    localparam logic [3:0]       CNT_FINAL  = 4'(MAX_RESULTS - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [2:0]                kind_reg, kind_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          end_idx_reg, end_idx_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      pend_vld_reg, pend_vld_next;
    logic [15:0]               pend_reading_reg, pend_reading_next;
    logic [3:0]                pend_index_reg, pend_index_next;
    logic [31:0]               tick_now_reg, tick_now_next;
    logic [31:0]               timeout_reg;
    logic [SENSOR_SLOTS-1:0]   online_reg, online_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    // slot memories, one read port registered at idx_reg
    logic [15:0]               reading_mem [SENSOR_SLOTS];
    logic [31:0]               stamp_mem   [SENSOR_SLOTS];
    logic [15:0]               rd_reading_reg;
    logic [31:0]               rd_stamp_reg;
    logic                      wr_en;

    logic                      id_ok;
    logic [IDX_W-1:0]          id_idx;
    logic [PAD_N-1:0]          online_pad;
    logic [31:0]               age;
    logic                      expired;
    logic                      found;
    logic                      cfg_wr;

    function automatic rsp_t make_rsp(input logic [2:0] kind, input logic ok,
                                      input logic [15:0] value, input logic [3:0] pos,
                                      input logic fin);
        rsp_t r;
        r.reply_kind = kind;
        r.ok         = ok;
        r.reading    = ok ? value : 16'd0;
        r.list_index = pos;
        r.last       = fin;
        return r;
    endfunction

    assign id_ok      = (req.slot_id < SLOTS_ID);
    assign id_idx     = req.slot_id[IDX_W-1:0];
    assign online_pad = PAD_N'(online_reg);

    // age unit: modular age of the fetched stamp against the timeout
    assign age     = tick_now_reg - rd_stamp_reg;
    assign expired = (age > timeout_reg);
    assign found   = online_pad[idx_reg];

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        idx_next          = idx_reg;
        end_idx_next      = end_idx_reg;
        cnt_next          = cnt_reg;
        pend_vld_next     = pend_vld_reg;
        pend_reading_next = pend_reading_reg;
        pend_index_next   = pend_index_reg;
        tick_now_next     = tick_now_reg;
        online_next       = online_reg;
        rsp_valid_next    = 1'b0;
        rsp_next          = rsp_reg;
        wr_en             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = req.req_type;
                    case (req.req_type)
                        REQ_UPDATE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (id_ok)
                            begin
                                wr_en               = 1'b1;
                                online_next[id_idx] = 1'b1;
                                rsp_next = make_rsp(REQ_UPDATE, 1'b1, req.temperature_in,
                                                    4'd0, 1'b1);
                            end
                            else
                            begin
                                rsp_next = make_rsp(REQ_UPDATE, 1'b0, 16'd0, 4'd0, 1'b1);
                            end
                        end
                        REQ_TICK:
                        begin
                            tick_now_next = tick_now_reg + 32'd1;
                            idx_next      = '0;
                            end_idx_next  = LAST_SLOT;
                            state_next    = S_FETCH;
                        end
                        REQ_READ_TEMP:
                        begin
                            if (id_ok && online_pad[id_idx])
                            begin
                                idx_next     = id_idx;
                                end_idx_next = id_idx;
                                state_next   = S_FETCH;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(REQ_READ_TEMP, 1'b0, 16'd0, 4'd0, 1'b1);
                            end
                        end
                        REQ_READ_ONLINE:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next = make_rsp(REQ_READ_ONLINE, id_ok && online_pad[id_idx],
                                                16'd0, 4'd0, 1'b1);
                        end
                        REQ_GATHER_ROOM:
                        begin
                            idx_next      = '0;
                            end_idx_next  = ROOM_LAST;
                            cnt_next      = '0;
                            pend_vld_next = 1'b0;
                            state_next    = S_FETCH;
                        end
                        REQ_GATHER_OUT:
                        begin
                            if (OUT_EMPTY)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(REQ_GATHER_OUT, 1'b0, 16'd0, 4'd0, 1'b1);
                            end
                            else
                            begin
                                idx_next      = OUT_FIRST;
                                end_idx_next  = LAST_SLOT;
                                cnt_next      = '0;
                                pend_vld_next = 1'b0;
                                state_next    = S_FETCH;
                            end
                        end
                        default:
                        begin
                            // unused codes: no result, no state change
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                // memory read of idx_reg completes at this edge
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                case (kind_reg)
                    REQ_TICK:
                    begin
                        if (found && expired)
                            online_next[idx_reg] = 1'b0;
                        if (idx_reg == end_idx_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next   = make_rsp(REQ_TICK, 1'b1, 16'd0, 4'd0, 1'b1);
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_FETCH;
                        end
                    end
                    REQ_READ_TEMP:
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next   = make_rsp(REQ_READ_TEMP, 1'b1, rd_reading_reg, 4'd0, 1'b1);
                        state_next = S_IDLE;
                    end
                    REQ_GATHER_ROOM, REQ_GATHER_OUT:
                    begin
                        // hold one entry back so the final one can carry last
                        if (found)
                        begin
                            if (pend_vld_reg)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(kind_reg, 1'b1, pend_reading_reg,
                                                    pend_index_reg, 1'b0);
                            end
                            pend_vld_next     = 1'b1;
                            pend_reading_next = rd_reading_reg;
                            pend_index_next   = cnt_reg;
                            cnt_next          = cnt_reg + 4'd1;
                        end
                        if ((idx_reg == end_idx_reg) || (found && (cnt_reg == CNT_FINAL)))
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FINISH:
            begin
                rsp_valid_next = 1'b1;
                if (pend_vld_reg)
                    rsp_next = make_rsp(kind_reg, 1'b1, pend_reading_reg, pend_index_reg, 1'b1);
                else
                    rsp_next = make_rsp(kind_reg, 1'b0, 16'd0, 4'd0, 1'b1);
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= REQ_UPDATE;
            idx_reg       <= '0;
            end_idx_reg   <= '0;
            cnt_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            tick_now_reg  <= '0;
            online_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
            end_idx_reg   <= end_idx_next;
            cnt_reg       <= cnt_next;
            pend_vld_reg  <= pend_vld_next;
            tick_now_reg  <= tick_now_next;
            online_reg    <= online_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_reading_reg <= pend_reading_next;
        pend_index_reg   <= pend_index_next;
        rsp_reg          <= rsp_next;
    end

    // slot memories: write on update, registered read at idx_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            reading_mem[id_idx] <= req.temperature_in;
            stamp_mem[id_idx]   <= tick_now_reg;
        end
        rd_reading_reg <= reading_mem[idx_reg];
        rd_stamp_reg   <= stamp_mem[idx_reg];
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_wr)
            timeout_reg <= pwdata;
    end

    assign prdata    = paddr[2] ? 32'd0 : timeout_reg;
    assign pready    = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(MAX_RESULTS))
        else $error("gather count beyond list limit");

    a_zero_reading: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.reading == 16'sd0)
        else $error("reading not zero on a failed result");

    a_multi_gather: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |->
            rsp.ok && (rsp.reply_kind == REQ_GATHER_ROOM || rsp.reply_kind == REQ_GATHER_OUT))
        else $error("non-final result outside a gather");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_SLOT && end_idx_reg <= LAST_SLOT)
        else $error("slot index out of table");

endmodule
